// ===== rtl/ccul_pkg.sv =====
// package for the coprime counter: widths and limits
// no dependencies
package ccul_pkg;
  localparam int unsigned ValueBitsDef = 32;
  localparam int unsigned PrimeBoundDef = 65536;
  localparam int unsigned MaxFactorsDef = 9;
  localparam int unsigned DataW = 32;
endpackage

// ===== rtl/ccul_div.sv =====
// restoring divider, one quotient bit per cycle
// depends on ccul_pkg
module ccul_div (
  input  logic                       clk_i,
  input  logic                       rst_ni,
  input  logic                       start_i,
  input  logic [ccul_pkg::DataW-1:0] num_i,
  input  logic [ccul_pkg::DataW-1:0] den_i,
  output logic                       done_o,
  output logic [ccul_pkg::DataW-1:0] quo_o,
  output logic [ccul_pkg::DataW-1:0] rem_o
);
  localparam int unsigned W = ccul_pkg::DataW;
  logic [W-1:0] q_q, r_q, d_q;
  logic [5:0] cnt_q;
  logic busy_q, done_q;
  logic [W:0] sh, diff;

  assign sh   = {r_q, q_q[W-1]};
  assign diff = sh - {1'b0, d_q};

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      done_q <= 1'b0;
      if (start_i) begin
        busy_q <= 1'b1;
        cnt_q  <= 6'(W);
        q_q    <= num_i;
        r_q    <= '0;
        d_q    <= den_i;
      end else if (busy_q) begin
        if (!diff[W]) begin
          r_q <= diff[W-1:0];
          q_q <= {q_q[W-2:0], 1'b1};
        end else begin
          r_q <= sh[W-1:0];
          q_q <= {q_q[W-2:0], 1'b0};
        end
        cnt_q <= cnt_q - 6'd1;
        if (cnt_q == 6'd1) begin
          busy_q <= 1'b0;
          done_q <= 1'b1;
        end
      end
    end
  end

  assign done_o = done_q;
  assign quo_o  = q_q;
  assign rem_o  = r_q;
endmodule

// ===== rtl/coprime_count_up_to_limit.sv =====
// coprime counter top level: sequencer, prime memory and factor memory
// depends on ccul_pkg and ccul_div
// After reset the prime memory is built in place before the first item is taken: a clearing
// pass over all PRIME_BOUND entries, a sieve that marks composites, then a compaction pass
// that reads each entry in ST_CPRD and, for a prime, stores its index in ST_CPWR. An item
// with value zero or one goes through ST_PRD and ST_SNEXT to ST_OUT with no division.
// Otherwise factoring walks the prime memory one prime at a time, each new prime tried in
// ST_PRD, ST_PTRY and ST_PDIV and each repeat trial after a hit in ST_PTRY and ST_PDIV,
// stopping once the cofactor is one; the subset phase then runs 2^k-1 subsets, each
// stepping through every factor in ST_SACC with one division per chosen factor. The shared
// one-bit-per-cycle divider sets the rate while out_ready_i does not hold ST_OUT.
module coprime_count_up_to_limit #(
  parameter int unsigned VALUE_BITS  = ccul_pkg::ValueBitsDef,
  parameter int unsigned PRIME_BOUND = ccul_pkg::PrimeBoundDef,
  parameter int unsigned MAX_FACTORS = ccul_pkg::MaxFactorsDef
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        in_valid_i,
  output logic        in_ready_o,
  input  logic [31:0] value_i,
  input  logic [31:0] limit_i,
  output logic        out_valid_o,
  input  logic        out_ready_i,
  output logic [31:0] coprime_count_o
);
  localparam int unsigned PW = $clog2(PRIME_BOUND);
  localparam int unsigned SW = PW / 2 + 1;
  localparam int unsigned FW = $clog2(MAX_FACTORS);
  localparam int unsigned CW = $clog2(MAX_FACTORS + 1);
  localparam int unsigned W = ccul_pkg::DataW;

  typedef enum logic [3:0] {
    ST_CLR, ST_SVRD, ST_SVCHK, ST_SVMARK, ST_CPRD, ST_CPWR, ST_IDLE, ST_PRD, ST_PTRY,
    ST_PDIV, ST_SNEXT, ST_SRD, ST_SDIV, ST_SACC, ST_OUT
  } state_e;

  state_e state_q;
  logic [15:0] prime_mem [PRIME_BOUND];
  logic [W-1:0] fact_mem [MAX_FACTORS];
  logic [PW-1:0] fill_q, nprime_q, pidx_q;
  logic [SW-1:0] sv_i_q;
  logic [PW:0] sv_j_q, sv_nxt;
  logic [2*SW-1:0] sv_sq;
  logic [15:0] prime_rd_q;
  logic [W-1:0] fact_rd_q;
  logic [W-1:0] v_q, lim_q, q_q, res_q;
  logic [33:0] acc_q;
  logic [CW-1:0] ftot_q, bit_q;
  logic [MAX_FACTORS-1:0] subset_q;
  logic par_q, hit_q;
  logic pm_we;
  logic [PW-1:0] pm_waddr;
  logic [15:0] pm_wdata;
  logic [PW-1:0] prd_addr;
  logic [FW-1:0] frd_addr;
  logic div_start, div_done;
  logic [W-1:0] div_num, div_den, div_quo, div_rem;

  assign sv_sq  = (2*SW)'(sv_i_q) * (2*SW)'(sv_i_q);
  assign sv_nxt = sv_j_q + (PW+1)'(sv_i_q);

  // clearing, composite marks and in-place compaction share the one write port
  assign pm_we = (state_q == ST_CLR) || (state_q == ST_SVMARK) ||
                 (state_q == ST_CPWR && prime_rd_q == '0);
  assign pm_waddr = (state_q == ST_CLR) ? fill_q :
                    (state_q == ST_SVMARK) ? sv_j_q[PW-1:0] : nprime_q;
  assign pm_wdata = (state_q == ST_CLR) ? '0 :
                    (state_q == ST_SVMARK) ? 16'd1 : 16'(fill_q);

  always_ff @(posedge clk_i) begin
    if (pm_we) prime_mem[pm_waddr] <= pm_wdata;
    prime_rd_q <= prime_mem[prd_addr];
  end
  always_ff @(posedge clk_i) begin
    if (state_q == ST_PDIV && div_done && div_rem == '0 && !hit_q && ftot_q < CW'(MAX_FACTORS))
      fact_mem[ftot_q[FW-1:0]] <= {16'd0, prime_rd_q};
    else if (state_q == ST_PRD && pidx_q == nprime_q && v_q > 1 &&
             ftot_q < CW'(MAX_FACTORS))
      fact_mem[ftot_q[FW-1:0]] <= v_q;
    fact_rd_q <= fact_mem[frd_addr];
  end
  assign prd_addr = (state_q == ST_CPRD) ? fill_q :
                    (state_q == ST_SVRD) ? PW'(sv_i_q) : pidx_q;
  assign frd_addr = bit_q[FW-1:0];

  assign div_start = (state_q == ST_PTRY) || (state_q == ST_SRD);
  assign div_num = (state_q == ST_PTRY) ? v_q : q_q;
  assign div_den = (state_q == ST_PTRY) ? {16'd0, prime_rd_q} : fact_rd_q;

  ccul_div u_div (
    .clk_i, .rst_ni, .start_i(div_start), .num_i(div_num), .den_i(div_den),
    .done_o(div_done), .quo_o(div_quo), .rem_o(div_rem)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q  <= ST_CLR;
      fill_q   <= '0;
      nprime_q <= '0;
      ftot_q   <= '0;
      acc_q    <= '0;
    end else begin
      unique case (state_q)
        ST_CLR: begin
          fill_q <= fill_q + PW'(1);
          if (fill_q == PW'(PRIME_BOUND - 1)) begin
            sv_i_q  <= SW'(2);
            state_q <= ST_SVRD;
          end
        end
        ST_SVRD: begin
          if (sv_sq >= (2*SW)'(PRIME_BOUND)) begin
            fill_q   <= PW'(2);
            nprime_q <= '0;
            state_q  <= ST_CPRD;
          end else begin
            state_q <= ST_SVCHK;
          end
        end
        ST_SVCHK: begin
          if (prime_rd_q == '0) begin
            sv_j_q  <= (PW+1)'(sv_sq);
            state_q <= ST_SVMARK;
          end else begin
            sv_i_q  <= sv_i_q + SW'(1);
            state_q <= ST_SVRD;
          end
        end
        ST_SVMARK: begin
          sv_j_q <= sv_nxt;
          if (sv_nxt >= (PW+1)'(PRIME_BOUND)) begin
            sv_i_q  <= sv_i_q + SW'(1);
            state_q <= ST_SVRD;
          end
        end
        ST_CPRD: state_q <= ST_CPWR;
        ST_CPWR: begin
          if (prime_rd_q == '0) nprime_q <= nprime_q + PW'(1);
          if (fill_q == PW'(PRIME_BOUND - 1)) begin
            state_q <= ST_IDLE;
          end else begin
            fill_q  <= fill_q + PW'(1);
            state_q <= ST_CPRD;
          end
        end
        ST_IDLE: begin
          if (in_valid_i) begin
            v_q    <= value_i & W'((64'd1 << VALUE_BITS) - 64'd1);
            lim_q  <= limit_i;
            ftot_q <= '0;
            acc_q  <= '0;
            pidx_q <= '0;
            hit_q  <= 1'b0;
            state_q <= ST_PRD;
          end
        end
        ST_PRD: begin
          if (v_q <= 1 || pidx_q == nprime_q) begin
            if (v_q > 1 && ftot_q < CW'(MAX_FACTORS)) ftot_q <= ftot_q + CW'(1);
            subset_q <= '0;
            state_q <= ST_SNEXT;
          end else begin
            state_q <= ST_PTRY;
          end
        end
        ST_PTRY: state_q <= ST_PDIV;
        ST_PDIV: begin
          if (div_done) begin
            if (div_rem == '0) begin
              if (!hit_q && ftot_q < CW'(MAX_FACTORS)) ftot_q <= ftot_q + CW'(1);
              hit_q <= 1'b1;
              v_q <= div_quo;
              state_q <= ST_PTRY;
            end else begin
              hit_q <= 1'b0;
              pidx_q <= pidx_q + PW'(1);
              state_q <= ST_PRD;
            end
          end
        end
        ST_SNEXT: begin
          if ((MAX_FACTORS+1)'(subset_q) + (MAX_FACTORS+1)'(1) ==
              ((MAX_FACTORS+1)'(1) << ftot_q)) begin
            res_q <= W'(34'(lim_q) - acc_q);
            state_q <= ST_OUT;
          end else begin
            subset_q <= subset_q + 1'b1;
            q_q <= lim_q;
            bit_q <= '0;
            par_q <= 1'b0;
            state_q <= ST_SACC;
          end
        end
        ST_SACC: begin
          if (bit_q == ftot_q) begin
            acc_q <= par_q ? acc_q + 34'(q_q) : acc_q - 34'(q_q);
            state_q <= ST_SNEXT;
          end else if (subset_q[bit_q[FW-1:0]]) begin
            state_q <= ST_SRD;
          end else begin
            bit_q <= bit_q + CW'(1);
          end
        end
        ST_SRD: state_q <= ST_SDIV;
        ST_SDIV: begin
          if (div_done) begin
            q_q <= div_quo;
            par_q <= ~par_q;
            bit_q <= bit_q + CW'(1);
            state_q <= ST_SACC;
          end
        end
        ST_OUT: if (out_ready_i) state_q <= ST_IDLE;
        default: state_q <= ST_IDLE;
      endcase
    end
  end

  assign in_ready_o = (state_q == ST_IDLE);
  assign out_valid_o = (state_q == ST_OUT);
  assign coprime_count_o = res_q;
endmodule

// ===== dv/tb_coprime_count_up_to_limit.sv =====
// testbench for coprime_count_up_to_limit: drives value/limit items through a
// clocked driver, predicts each coprime count and checks results in a monitor
// depends on ccul_pkg and the rtl of the block
`timescale 1ns / 100ps

module tb_coprime_count_up_to_limit;
  localparam int unsigned DataW = ccul_pkg::DataW;
  localparam int unsigned MaxFactorsDef = ccul_pkg::MaxFactorsDef;
  localparam int unsigned PrimeBoundDef = ccul_pkg::PrimeBoundDef;

  typedef struct packed {
    logic [DataW-1:0] value;
    logic [DataW-1:0] limit;
  } query_t;

  localparam int unsigned WatchdogLimit = 2000000;

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic in_valid = 1'b0;
  logic in_ready;
  logic [DataW-1:0] value = '0;
  logic [DataW-1:0] limit = '0;
  logic out_valid;
  logic out_ready = 1'b0;
  logic [DataW-1:0] coprime_count;

  query_t pending_q[$];
  logic [DataW-1:0] count_q[$];
  int unsigned prime_list[$];
  int unsigned send_idle_pct = 0;
  int unsigned recv_stall_pct = 0;
  int unsigned mismatches = 0;
  int unsigned quiet_cycles = 0;

  coprime_count_up_to_limit i_dut (
    .clk_i          (clk),
    .rst_ni         (rst_n),
    .in_valid_i     (in_valid),
    .in_ready_o     (in_ready),
    .value_i        (value),
    .limit_i        (limit),
    .out_valid_o    (out_valid),
    .out_ready_i    (out_ready),
    .coprime_count_o(coprime_count)
  );

  initial begin
    forever #10 clk = ~clk;
  end

  function automatic logic [DataW-1:0] coprimes_up_to(input logic [DataW-1:0] v_in,
                                                      input logic [DataW-1:0] lim);
    longint unsigned v;
    longint unsigned q;
    longint signed acc;
    longint unsigned factors[$];
    int unsigned bits;
    v = v_in;
    acc = 0;
    if (v <= 1) return lim;
    foreach (prime_list[i]) begin
      if (v <= 1) break;
      if (v % prime_list[i] == 0) begin
        if (factors.size() < MaxFactorsDef) factors.insert(factors.size(), prime_list[i]);
        while (v % prime_list[i] == 0) v = v / prime_list[i];
      end
    end
    if (v > 1 && factors.size() < MaxFactorsDef) factors.insert(factors.size(), v);
    for (int s = 1; s < (1 << factors.size()); s++) begin
      q = lim;
      bits = 0;
      foreach (factors[i]) begin
        if ((s >> i) & 1) begin
          q = q / factors[i];
          bits++;
        end
      end
      if (bits & 1) acc += longint'(q);
      else acc -= longint'(q);
    end
    return DataW'(longint'(lim) - acc);
  endfunction

  // smooth value from the first primes, sometimes times a mid-sized prime
  function automatic query_t random_query();
    query_t qry;
    longint unsigned v;
    longint unsigned p;
    int unsigned picks;
    v = 1;
    picks = $urandom_range(1, 5);
    for (int n = 0; n < picks; n++) begin
      p = prime_list[$urandom_range(0, 14)];
      for (int e = $urandom_range(1, 4); e > 0; e--) begin
        if (v * p <= 64'hFFFF_FFFF) v = v * p;
      end
    end
    if ($urandom_range(0, 9) == 0) begin
      p = prime_list[$urandom_range(15, 200)];
      if (v * p <= 64'hFFFF_FFFF) v = v * p;
    end
    qry.value = DataW'(v);
    case ($urandom_range(0, 3))
      0:       qry.limit = $urandom_range(0, 1000);
      default: qry.limit = $urandom();
    endcase
    return qry;
  endfunction

  // driver
  always @(posedge clk) begin
    if (rst_n) begin
      if (!in_valid || in_ready) begin
        if (pending_q.size() > 0 && $urandom_range(0, 99) >= send_idle_pct) begin
          in_valid <= 1'b1;
          value <= pending_q[0].value;
          limit <= pending_q[0].limit;
          count_q.insert(count_q.size(),
                         coprimes_up_to(pending_q[0].value, pending_q[0].limit));
          void'(pending_q.pop_front());
        end else begin
          in_valid <= 1'b0;
        end
      end
    end
  end

  // monitor
  always @(posedge clk) begin
    if (rst_n) begin
      out_ready <= ($urandom_range(0, 99) >= recv_stall_pct);
      if (out_valid && out_ready) begin
        if (count_q.size() == 0) begin
          mismatches++;
          if (mismatches <= 10) $display("unexpected item: coprime_count %0d", coprime_count);
        end else begin
          if (coprime_count !== count_q[0]) begin
            mismatches++;
            if (mismatches <= 10)
              $display("coprime_count mismatch: expected %0d actual %0d",
                       count_q[0], coprime_count);
          end
          void'(count_q.pop_front());
        end
      end
    end
  end

  // watchdog
  always @(posedge clk) begin
    if ((in_valid && in_ready) || (out_valid && out_ready)) quiet_cycles <= 0;
    else quiet_cycles <= quiet_cycles + 1;
    if (quiet_cycles >= WatchdogLimit) begin
      $display("Verification failed");
      $finish;
    end
  end

  task automatic add_query(input logic [DataW-1:0] v, input logic [DataW-1:0] lim);
    query_t qry;
    qry.value = v;
    qry.limit = lim;
    pending_q.insert(pending_q.size(), qry);
  endtask

  task automatic drain();
    while (pending_q.size() > 0 || in_valid || count_q.size() > 0) @(posedge clk);
  endtask

  initial begin
    bit composite[PrimeBoundDef];
    for (int i = 2; i < PrimeBoundDef; i++) begin
      if (!composite[i]) begin
        prime_list.insert(prime_list.size(), i);
        for (longint j = longint'(i) * i; j < PrimeBoundDef; j += i) composite[j] = 1'b1;
      end
    end
    repeat (8) @(posedge clk);
    rst_n <= 1'b1;

    // directed: extremes and special cases, no idling
    add_query(32'd1, 32'd12345);
    add_query(32'd0, 32'd777);
    add_query(32'd30, 32'd0);
    add_query(32'd1, 32'hFFFF_FFFF);
    add_query(32'd2, 32'hFFFF_FFFF);
    add_query(32'd6, 32'd1);
    add_query(32'h8000_0000, 32'hAAAA_AAAA);
    add_query(32'd223092870, 32'hFFFF_FFFF);
    add_query(32'd4294967291, 32'h5555_5555);
    add_query(32'hFFFF_FFFF, 32'hFFFF_FFFF);
    add_query(32'd65521, 32'd1000000);
    add_query(32'd65521 * 32'd3, 32'd65521);
    add_query(32'd7, 32'd6);
    add_query(32'd1024, 32'd100000);
    drain();

    for (int ph = 0; ph < 5; ph++) begin
      case (ph)
        0: begin send_idle_pct = 0;  recv_stall_pct = 0;  end
        1: begin send_idle_pct = 86; recv_stall_pct = 0;  end
        2: begin send_idle_pct = 0;  recv_stall_pct = 86; end
        3: begin send_idle_pct = 11; recv_stall_pct = 11; end
        default: begin send_idle_pct = 0; recv_stall_pct = 0; end
      endcase
      for (int n = 0; n < 20; n++) pending_q.insert(pending_q.size(), random_query());
      drain();
    end

    repeat (200) @(posedge clk);
    if (mismatches == 0 && count_q.size() == 0) begin
      $display("Verification passed");
    end else begin
      $display("Verification failed");
    end
    $finish;
  end

endmodule
